### src/nsr_pkg.sv
// Shared constants, types and state encoding for the Newton square root block.
package nsr_pkg;

  localparam int FRACTION_BITS  = 32;
  localparam int MAX_ITERATIONS = 64;

  localparam int VAL_W  = 64;
  localparam int ROOT_W = 63;
  localparam int TOL_W  = 63;

  localparam int DIVD_W = ROOT_W + FRACTION_BITS;
  localparam int CNT_W  = $clog2(DIVD_W);
  localparam int ITER_W = $clog2(MAX_ITERATIONS);

  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(430);
  localparam logic [VAL_W-1:0] ONE_VAL   = VAL_W'(1) << FRACTION_BITS;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_UPD,
    ST_CHK,
    ST_DONE
  } nsr_state_t;

endpackage

### src/newton_square_root.sv
// Top level: fixed-point Newton-Raphson square root with a shared bit-serial divider.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in_     | slave     | in_tvalid/in_tready  | tdata[63:0] value (signed Q31.32)
//  out_    | master    | out_tvalid/out_tready| tdata[62:0] root, [63] zero; tuser[0] invalid,
//          |           |                      | tuser[1] capped
//  cfg_    | slave     | cfg_valid/cfg_ready  | cfg_data[62:0] tolerance (Q31.32)
//
// Negative, zero and one values go straight to the final state. Otherwise each Newton step
// shifts all DIVD_W dividend bits through the divider, then does one update and one
// convergence check; an item takes at most MAX_ITERATIONS steps. The restoring
// divider retires one quotient bit a cycle.
// Reset clears control state and loads the tolerance with 430 (about 1e-7).
// in_tready is high only while idle; a finished result waits in the output register,
// and the block stalls in its final state only if a previous result is still unclaimed.
module newton_square_root (
  input  logic                       clk,
  input  logic                       rst_n,
  // in_tdata: [63:0] value
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [nsr_pkg::VAL_W-1:0]  in_tdata,
  // out_tdata: [62:0] root, [63] zero fill
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [63:0]                out_tdata,
  // out_tuser: [0] invalid, [1] capped
  output logic [1:0]                 out_tuser,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [nsr_pkg::TOL_W-1:0]  cfg_data
);

  localparam int ROOT_W = nsr_pkg::ROOT_W;
  localparam int DIVD_W = nsr_pkg::DIVD_W;
  localparam int CNT_W  = nsr_pkg::CNT_W;
  localparam int ITER_W = nsr_pkg::ITER_W;

  nsr_pkg::nsr_state_t state_r, state_nxt;

  logic [nsr_pkg::TOL_W-1:0] tol_r;
  logic [ROOT_W-1:0]         val_r, val_nxt;     // radicand, known non-negative
  logic [ROOT_W-1:0]         last_r, last_nxt;   // current guess, also the divisor
  logic [ROOT_W-1:0]         next_r, next_nxt;   // freshly formed guess
  logic [DIVD_W-1:0]         divd_r, divd_nxt;   // dividend bits still to shift in
  logic [63:0]               rem_r, rem_nxt;
  logic [63:0]               quo_r, quo_nxt;
  logic                      ovf_r, ovf_nxt;     // a quotient bit fell off the top
  logic [CNT_W-1:0]          bitcnt_r, bitcnt_nxt;
  logic [ITER_W-1:0]         iter_r, iter_nxt;
  logic [ROOT_W-1:0]         res_root_r, res_root_nxt;
  logic                      res_inv_r, res_inv_nxt;
  logic                      res_cap_r, res_cap_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [ROOT_W-1:0]         out_root_r, out_root_nxt;
  logic                      out_inv_r, out_inv_nxt;
  logic                      out_cap_r, out_cap_nxt;

  // Divider step: shift one dividend bit into the remainder, subtract when it fits.
  logic [63:0] rem_sh;
  logic [64:0] rem_sub;
  logic        rem_ge;
  // Guess update and convergence check.
  logic [63:0]       q_sat;
  logic [63:0]       guess_sum;
  logic [ROOT_W-1:0] guess_diff;
  logic              in_xfer;

  assign rem_sh  = {rem_r[62:0], divd_r[DIVD_W-1]};
  assign rem_sub = {1'b0, rem_sh} - {2'b00, last_r};
  assign rem_ge  = ~rem_sub[64];

  assign q_sat     = ovf_r ? '1 : quo_r;
  assign guess_sum = {2'b00, last_r[ROOT_W-1:1]} + {1'b0, q_sat[63:1]}
                   + 64'(last_r[0] & q_sat[0]);
  assign guess_diff = (next_r > last_r) ? (next_r - last_r) : (last_r - next_r);

  assign in_tready = (state_r == nsr_pkg::ST_IDLE);
  assign in_xfer   = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_root_r};
  assign out_tuser  = {out_cap_r, out_inv_r};

  always_comb begin
    state_nxt     = state_r;
    val_nxt       = val_r;
    last_nxt      = last_r;
    next_nxt      = next_r;
    divd_nxt      = divd_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    ovf_nxt       = ovf_r;
    bitcnt_nxt    = bitcnt_r;
    iter_nxt      = iter_r;
    res_root_nxt  = res_root_r;
    res_inv_nxt   = res_inv_r;
    res_cap_nxt   = res_cap_r;
    out_valid_nxt = out_valid_r;
    out_root_nxt  = out_root_r;
    out_inv_nxt   = out_inv_r;
    out_cap_nxt   = out_cap_r;

    // Drop the result once the downstream side takes the transaction.
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      nsr_pkg::ST_IDLE: begin
        if (in_xfer) begin
          res_inv_nxt  = 1'b0;
          res_cap_nxt  = 1'b0;
          res_root_nxt = in_tdata[ROOT_W-1:0];
          priority if (in_tdata[nsr_pkg::VAL_W-1]) begin
            // Negative radicand: flag it, no root.
            res_inv_nxt  = 1'b1;
            res_root_nxt = '0;
            state_nxt    = nsr_pkg::ST_DONE;
          end else if (in_tdata == '0 || in_tdata == nsr_pkg::ONE_VAL) begin
            state_nxt = nsr_pkg::ST_DONE;
          end else begin
            // First guess is the value itself; start the first division.
            val_nxt    = in_tdata[ROOT_W-1:0];
            last_nxt   = in_tdata[ROOT_W-1:0];
            divd_nxt   = {in_tdata[ROOT_W-1:0], nsr_pkg::FRACTION_BITS'(0)};
            rem_nxt    = '0;
            quo_nxt    = '0;
            ovf_nxt    = 1'b0;
            bitcnt_nxt = CNT_W'(DIVD_W - 1);
            iter_nxt   = '0;
            state_nxt  = nsr_pkg::ST_DIV;
          end
        end
      end
      nsr_pkg::ST_DIV: begin
        rem_nxt  = rem_ge ? rem_sub[63:0] : rem_sh;
        quo_nxt  = {quo_r[62:0], rem_ge};
        ovf_nxt  = ovf_r | quo_r[63];
        divd_nxt = divd_r << 1;
        if (bitcnt_r == '0) begin
          state_nxt = nsr_pkg::ST_UPD;
        end else begin
          bitcnt_nxt = bitcnt_r - CNT_W'(1);
        end
      end
      nsr_pkg::ST_UPD: begin
        // Mean of guess and quotient, saturated to the root field.
        next_nxt  = guess_sum[63] ? '1 : guess_sum[ROOT_W-1:0];
        state_nxt = nsr_pkg::ST_CHK;
      end
      nsr_pkg::ST_CHK: begin
        res_root_nxt = next_r;
        priority if (guess_diff <= tol_r) begin
          res_cap_nxt = 1'b0;
          state_nxt   = nsr_pkg::ST_DONE;
        end else if (iter_r == ITER_W'(nsr_pkg::MAX_ITERATIONS - 1)) begin
          res_cap_nxt = 1'b1;
          state_nxt   = nsr_pkg::ST_DONE;
        end else begin
          // Advance to the next Newton step with the new guess as divisor.
          last_nxt   = next_r;
          divd_nxt   = {val_r, nsr_pkg::FRACTION_BITS'(0)};
          rem_nxt    = '0;
          quo_nxt    = '0;
          ovf_nxt    = 1'b0;
          bitcnt_nxt = CNT_W'(DIVD_W - 1);
          iter_nxt   = iter_r + ITER_W'(1);
          state_nxt  = nsr_pkg::ST_DIV;
        end
      end
      nsr_pkg::ST_DONE: begin
        // Hold until the output register is free.
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_root_nxt  = res_root_r;
          out_inv_nxt   = res_inv_r;
          out_cap_nxt   = res_cap_r;
          state_nxt     = nsr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = nsr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= nsr_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      tol_r       <= nsr_pkg::TOL_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        tol_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    last_r     <= last_nxt;
    next_r     <= next_nxt;
    divd_r     <= divd_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    ovf_r      <= ovf_nxt;
    bitcnt_r   <= bitcnt_nxt;
    iter_r     <= iter_nxt;
    res_root_r <= res_root_nxt;
    res_inv_r  <= res_inv_nxt;
    res_cap_r  <= res_cap_nxt;
    out_root_r <= out_root_nxt;
    out_inv_r  <= out_inv_nxt;
    out_cap_r  <= out_cap_nxt;
  end

endmodule

### src/nsr_checker.sv
// Port-level checker for the Newton square root block, bound to the top level.
module nsr_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_tvalid,
  input logic                      in_tready,
  input logic                      out_tvalid,
  input logic                      out_tready,
  input logic [63:0]               out_tdata,
  input logic [1:0]                out_tuser
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // An invalid result carries a zero root and no cap flag.
  a_invalid_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 64'd0 && !out_tuser[1])
    else $error("invalid result with nonzero root or cap");

  // The block is busy right after it takes an input transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("ready again right after an accepted transaction");

  // No result is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind newton_square_root nsr_checker u_nsr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
